// File: design/lbbg_pkg.sv
// Package for the lamp blink burst generator: item types, action codes and register indexes.
`default_nettype none

package lbbg_pkg;

    // Action codes carried in the action field of an input item
    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_BLINK   = 3'd1;
    localparam logic [2:0] ACT_REPEAT  = 3'd2;
    localparam logic [2:0] ACT_FLICKER = 3'd3;
    localparam logic [2:0] ACT_OFF     = 3'd4;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_ON    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_OFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLICKER_ON  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLICKER_OFF = 3'd3;

    // Register reset values, milliseconds
    localparam logic [15:0] BLINK_TIME_RST   = 16'd250;
    localparam logic [15:0] FLICKER_TIME_RST = 16'd100;

    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  blink_count;
        logic [15:0] gap_time;
    } in_item_t;

    typedef struct packed {
        logic        lamp;
        logic        busy_res;
        logic [7:0]  blinks_left;
        logic [15:0] burst_total;
    } out_item_t;

endpackage

`default_nettype wire

// File: design/lamp_blink_burst_generator.sv
// Lamp blink burst generator top level: pattern state, command decode and result queue.
//
// Usage:
//   in channel   : in_valid / in_stall / in_item. Each item is a one-millisecond tick
//                  or a command (blink, repeat, flicker, off). An item is taken at a
//                  clock edge with in_valid high and in_stall low.
//   out channel  : out_valid / out_stall / out_item. Exactly one result per input
//                  item: lamp, busy flag, blinks left and wrapping burst count.
//   cfg channel  : cfg_valid / cfg_ready / cfg_index / cfg_data. cfg_ready is always
//                  high; indexes 0..3 select the four timing registers, others are
//                  ignored. Write only while the block is idle.
// Result path: each result is formed combinationally and queued as its item is taken.
// Throughput: one item per cycle while in_stall is low; the pattern update is a single
//   compare and subtract on the 16-bit elapsed counter, done in the cycle the item arrives.
// Stall: results queue in a two-entry output buffer, so an item is still taken
//   while one result waits; in_stall rises only when both entries are full.
// Reset: rst_n clears the pattern (lamp dark, burst count zero), empties the
//   queue and loads the timing registers with 250/250/100/100 ms.
`default_nettype none

module lamp_blink_burst_generator
    import lbbg_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire in_item_t        in_item,
    output logic                 out_valid,
    input  wire                  out_stall,
    output out_item_t            out_item,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [15:0]           cfg_data
);

    // Timing registers
    logic [15:0] blink_on_reg, blink_off_reg, flicker_on_reg, flicker_off_reg;

    // Pattern state
    logic [7:0]  burst_size_reg, burst_size_next;
    logic [7:0]  remaining_reg, remaining_next;
    logic        in_on_reg, in_on_next;
    logic        repeating_reg, repeating_next;
    logic [15:0] on_time_reg, on_time_next;
    logic [15:0] off_time_reg, off_time_next;
    logic [15:0] gap_reg, gap_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] bursts_reg, bursts_next;
    logic        lamp_reg, lamp_next;

    // Result queue
    out_item_t   slot0_reg, slot0_next, slot1_reg, slot1_next;
    logic [1:0]  count_reg, count_next;

    logic        push, pop;
    logic [15:0] elapsed_inc;
    logic [15:0] phase;
    logic [7:0]  rem_dec;
    out_item_t   result;

    assign cfg_ready = 1'b1;
    assign in_stall  = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = slot0_reg;
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;

    // Write the timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_on_reg    <= BLINK_TIME_RST;
            blink_off_reg   <= BLINK_TIME_RST;
            flicker_on_reg  <= FLICKER_TIME_RST;
            flicker_off_reg <= FLICKER_TIME_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BLINK_ON:    blink_on_reg    <= cfg_data;
                REG_BLINK_OFF:   blink_off_reg   <= cfg_data;
                REG_FLICKER_ON:  flicker_on_reg  <= cfg_data;
                REG_FLICKER_OFF: flicker_off_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 16'd1;
    assign phase       = in_on_reg ? on_time_reg : off_time_reg;
    assign rem_dec     = remaining_reg - 8'd1;

    // Work out the next pattern state for the incoming item
    always_comb
    begin
        burst_size_next = burst_size_reg;
        remaining_next  = remaining_reg;
        in_on_next      = in_on_reg;
        repeating_next  = repeating_reg;
        on_time_next    = on_time_reg;
        off_time_next   = off_time_reg;
        gap_next        = gap_reg;
        elapsed_next    = elapsed_reg;
        bursts_next     = bursts_reg;
        lamp_next       = lamp_reg;

        unique case (in_item.action)
            ACT_TICK:
            begin
                elapsed_next = elapsed_inc;
                if (remaining_reg == 8'd0)
                begin
                    // Gap expiry starts a new burst
                    if (repeating_reg && (elapsed_inc >= gap_reg))
                    begin
                        remaining_next = burst_size_reg;
                        in_on_next     = 1'b1;
                        elapsed_next   = 16'd0;
                        bursts_next    = bursts_reg + 16'd1;
                        lamp_next      = 1'b1;
                    end
                end
                else if (elapsed_inc >= phase)
                begin
                    elapsed_next = elapsed_inc - phase;
                    if (in_on_reg)
                    begin
                        in_on_next = 1'b0;
                        lamp_next  = 1'b0;
                    end
                    else
                    begin
                        remaining_next = rem_dec;
                        if (rem_dec != 8'd0)
                        begin
                            in_on_next = 1'b1;
                            lamp_next  = 1'b1;
                        end
                    end
                end
            end
            ACT_BLINK, ACT_REPEAT, ACT_FLICKER, ACT_OFF:
            begin
                if ((in_item.action == ACT_OFF) || ((in_item.action != ACT_FLICKER)
                    && (in_item.blink_count == 8'd0)))
                begin
                    // Drop the pattern and darken the lamp
                    burst_size_next = 8'd0;
                    remaining_next  = 8'd0;
                    in_on_next      = 1'b0;
                    repeating_next  = 1'b0;
                    on_time_next    = 16'd0;
                    off_time_next   = 16'd0;
                    gap_next        = 16'd0;
                    elapsed_next    = 16'd0;
                    lamp_next       = 1'b0;
                end
                else
                begin
                    // Latch the pattern and start a burst at once
                    if (in_item.action == ACT_FLICKER)
                    begin
                        burst_size_next = 8'd1;
                        repeating_next  = 1'b1;
                        gap_next        = 16'd0;
                        on_time_next    = flicker_on_reg;
                        off_time_next   = flicker_off_reg;
                        remaining_next  = 8'd1;
                    end
                    else
                    begin
                        burst_size_next = in_item.blink_count;
                        repeating_next  = (in_item.action == ACT_REPEAT);
                        gap_next        = (in_item.action == ACT_REPEAT) ?
                                          in_item.gap_time : 16'd0;
                        on_time_next    = blink_on_reg;
                        off_time_next   = blink_off_reg;
                        remaining_next  = in_item.blink_count;
                    end
                    in_on_next   = 1'b1;
                    elapsed_next = 16'd0;
                    bursts_next  = bursts_reg + 16'd1;
                    lamp_next    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Form the result from the updated state
    always_comb
    begin
        result.lamp        = lamp_next;
        result.busy_res    = (remaining_next != 8'd0) && !repeating_next;
        result.blinks_left = remaining_next;
        result.burst_total = bursts_next;
    end

    // Advance the pattern state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_size_reg <= 8'd0;
            remaining_reg  <= 8'd0;
            in_on_reg      <= 1'b0;
            repeating_reg  <= 1'b0;
            on_time_reg    <= 16'd0;
            off_time_reg   <= 16'd0;
            gap_reg        <= 16'd0;
            elapsed_reg    <= 16'd0;
            bursts_reg     <= 16'd0;
            lamp_reg       <= 1'b0;
        end
        else if (push)
        begin
            burst_size_reg <= burst_size_next;
            remaining_reg  <= remaining_next;
            in_on_reg      <= in_on_next;
            repeating_reg  <= repeating_next;
            on_time_reg    <= on_time_next;
            off_time_reg   <= off_time_next;
            gap_reg        <= gap_next;
            elapsed_reg    <= elapsed_next;
            bursts_reg     <= bursts_next;
            lamp_reg       <= lamp_next;
        end
    end

    // Queue control: push results, pop on a taken item
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    slot0_next = result;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    slot0_next = result;
                end
                else if (push)
                begin
                    slot1_next = result;
                    count_next = 2'd2;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    slot0_next = slot1_reg;
                    count_next = 2'd1;
                end
            end
            default: count_next = 2'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Hold the queued result payloads
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

// File: tb/tb_lamp_blink_burst_generator.sv
// Self-checking testbench for the lamp blink burst generator: directed, long-phase and random items.
`timescale 1ns / 1ps

module tb_lamp_blink_burst_generator;
    import lbbg_pkg::*;

    // Index with no register behind it; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
    localparam int NUM_ACTIONS = 2 ** $bits(ACT_OFF);
    localparam int WATCHDOG_LIMIT = 2000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_item;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    // Shadow copies of the timing registers
    logic [15:0] reg_blink_on    = BLINK_TIME_RST;
    logic [15:0] reg_blink_off   = BLINK_TIME_RST;
    logic [15:0] reg_flicker_on  = FLICKER_TIME_RST;
    logic [15:0] reg_flicker_off = FLICKER_TIME_RST;

    // Predicted pattern state
    logic [7:0]  pat_size    = '0;
    logic [7:0]  blinks_rem  = '0;
    logic        on_phase    = 1'b0;
    logic        rep_mode    = 1'b0;
    logic [15:0] on_ms       = '0;
    logic [15:0] off_ms      = '0;
    logic [15:0] gap_ms      = '0;
    logic [15:0] elapsed_ms  = '0;
    logic [15:0] burst_cnt   = '0;
    logic        lamp_lit    = 1'b0;

    out_item_t pending_status[$];
    int        errors = 0;
    bit        tx_idle_on = 1'b1;
    bit        rx_idle_on = 1'b1;
    int        stall_left = 0;
    int        quiet_cycles = 0;

    lamp_blink_burst_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Start a burst of the latched size with the lamp lit
    function automatic void start_burst();
        blinks_rem = pat_size;
        on_phase   = 1'b1;
        elapsed_ms = '0;
        burst_cnt  = burst_cnt + 16'd1;
        lamp_lit   = 1'b1;
    endfunction

    // Drop the pattern and darken the lamp
    function automatic void clear_pattern();
        blinks_rem = '0;
        on_phase   = 1'b0;
        elapsed_ms = '0;
        pat_size   = '0;
        rep_mode   = 1'b0;
        gap_ms     = '0;
        on_ms      = '0;
        off_ms     = '0;
        lamp_lit   = 1'b0;
    endfunction

    // Advance the predicted state by one item and return the status it reports
    function automatic out_item_t next_lamp_status(input in_item_t it);
        out_item_t   st;
        logic [15:0] phase_len;
        case (it.action)
            ACT_TICK:
            begin
                if (elapsed_ms != ELAPSED_MAX)
                    elapsed_ms = elapsed_ms + 16'd1;
                if (blinks_rem == '0)
                begin
                    if (rep_mode && elapsed_ms >= gap_ms)
                        start_burst();
                end
                else
                begin
                    phase_len = on_phase ? on_ms : off_ms;
                    if (elapsed_ms >= phase_len)
                    begin
                        elapsed_ms = elapsed_ms - phase_len;
                        if (on_phase)
                        begin
                            on_phase = 1'b0;
                            lamp_lit = 1'b0;
                        end
                        else
                        begin
                            blinks_rem = blinks_rem - 8'd1;
                            if (blinks_rem != '0)
                            begin
                                on_phase = 1'b1;
                                lamp_lit = 1'b1;
                            end
                        end
                    end
                end
            end
            ACT_BLINK, ACT_REPEAT:
            begin
                if (it.blink_count == '0)
                    clear_pattern();
                else
                begin
                    pat_size = it.blink_count;
                    rep_mode = (it.action == ACT_REPEAT);
                    gap_ms   = (it.action == ACT_REPEAT) ? it.gap_time : 16'd0;
                    on_ms    = reg_blink_on;
                    off_ms   = reg_blink_off;
                    start_burst();
                end
            end
            ACT_FLICKER:
            begin
                pat_size = 8'd1;
                rep_mode = 1'b1;
                gap_ms   = '0;
                on_ms    = reg_flicker_on;
                off_ms   = reg_flicker_off;
                start_burst();
            end
            ACT_OFF:
                clear_pattern();
            default:
                ;
        endcase
        st.lamp        = lamp_lit;
        st.busy_res    = (blinks_rem != '0) && !rep_mode;
        st.blinks_left = blinks_rem;
        st.burst_total = burst_cnt;
        return st;
    endfunction

    // Send one item, with an occasional idle burst ahead of it; returns at a falling edge
    task automatic send(input logic [2:0] act, input logic [7:0] cnt, input logic [15:0] gap);
        in_item_t it;
        it.action      = act;
        it.blink_count = cnt;
        it.gap_time    = gap;
        if (tx_idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
        pending_status.push_back(next_lamp_status(it));
        @(negedge clk);
    endtask

    // Hold the sender until every predicted status has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Write all four timing registers, then one index with no register behind it
    task automatic write_timing(input logic [15:0] b_on, input logic [15:0] b_off,
                                input logic [15:0] f_on, input logic [15:0] f_off);
        logic [CFG_IDX_W-1:0] idx [5];
        logic [15:0]          val [5];
        idx[0] = REG_BLINK_ON;    val[0] = b_on;
        idx[1] = REG_BLINK_OFF;   val[1] = b_off;
        idx[2] = REG_FLICKER_ON;  val[2] = f_on;
        idx[3] = REG_FLICKER_OFF; val[3] = f_off;
        idx[4] = REG_UNUSED;      val[4] = 16'($urandom);
        wait_idle();
        cfg_valid <= 1'b1;
        for (int k = 0; k < 5; k++)
        begin
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx[k])
                REG_BLINK_ON:    reg_blink_on    = val[k];
                REG_BLINK_OFF:   reg_blink_off   = val[k];
                REG_FLICKER_ON:  reg_flicker_on  = val[k];
                REG_FLICKER_OFF: reg_flicker_off = val[k];
                default:         ;
            endcase
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Every command with extreme fields, zero counts and reserved actions, at reset timing
    task automatic test_commands();
        send(ACT_TICK, 8'hFF, 16'hFFFF);
        send(ACT_BLINK, 8'd0, 16'hFFFF);
        send(ACT_REPEAT, 8'd0, 16'hFFFF);
        for (int a = ACT_OFF + 1; a < NUM_ACTIONS; a++)
            send(a[2:0], 8'hFF, 16'hFFFF);
        send(ACT_BLINK, 8'hFF, 16'hFFFF);
        repeat (3) send(ACT_TICK, 8'd0, 16'd0);
        for (int a = ACT_OFF + 1; a < NUM_ACTIONS; a++)
            send(a[2:0], 8'd0, 16'd0);
        send(ACT_FLICKER, 8'hFF, 16'hFFFF);
        send(ACT_TICK, 8'hFF, 16'hFFFF);
        send(ACT_OFF, 8'hFF, 16'hFFFF);
        send(ACT_REPEAT, 8'd1, 16'd0);
        send(ACT_TICK, 8'd0, 16'd0);
        send(ACT_OFF, 8'd0, 16'd0);
    endtask

    // Zero-length phases: one transition per tick, gap measured from the last off phase
    task automatic test_zero_phase();
        write_timing(16'd0, 16'd0, 16'd0, 16'd0);
        send(ACT_BLINK, 8'd2, 16'hFFFF);
        repeat (5) send(ACT_TICK, 8'd0, 16'd0);
        send(ACT_REPEAT, 8'd1, 16'd3);
        repeat (8) send(ACT_TICK, 8'd0, 16'd0);
        send(ACT_FLICKER, 8'd0, 16'd0);
        repeat (4) send(ACT_TICK, 8'd0, 16'd0);
    endtask

    // Longest on phase: ticks leave it running, then a repeat with the longest gap
    task automatic test_long_phase();
        write_timing(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
        send(ACT_BLINK, 8'd1, 16'd0);
        repeat (40) send(ACT_TICK, 8'($urandom), 16'($urandom));
        send(ACT_REPEAT, 8'd1, 16'hFFFF);
        send(ACT_OFF, 8'd0, 16'd0);
    endtask

    // Start bursts back to back with short timing, ticks in between
    task automatic test_burst_run();
        write_timing(16'd1, 16'd1, 16'd1, 16'd1);
        for (int n = 0; n < 48; n++)
        begin
            if (n % 8 == 7)
                send(ACT_TICK, 8'($urandom), 16'($urandom));
            else
                send(3'($urandom_range(ACT_BLINK, ACT_FLICKER)), 8'($urandom_range(1, 255)),
                     16'($urandom));
        end
    endtask

    // Random timing per phase; mostly ticks and well-formed commands, some noise
    task automatic test_random();
        logic [15:0] t [4];
        int          r;
        for (int ph = 0; ph < 4; ph++)
        begin
            foreach (t[k])
                t[k] = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
            write_timing(t[0], t[1], t[2], t[3]);
            if (ph == 3)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            for (int n = 0; n < 260; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    send(ACT_TICK, 8'($urandom), 16'($urandom));
                else if (r < 78)
                    send(ACT_BLINK, (r == 70) ? 8'($urandom) : 8'($urandom_range(1, 4)),
                         16'($urandom));
                else if (r < 86)
                    send(ACT_REPEAT, (r == 78) ? 8'($urandom) : 8'($urandom_range(1, 3)),
                         (r == 79) ? 16'($urandom) : 16'($urandom_range(0, 8)));
                else if (r < 90)
                    send(ACT_FLICKER, 8'($urandom), 16'($urandom));
                else if (r < 94)
                    send(ACT_OFF, 8'($urandom), 16'($urandom));
                else
                    send(3'($urandom_range(0, NUM_ACTIONS - 1)), 8'($urandom), 16'($urandom));
            end
        end
    endtask

    // Random stall bursts on the result side
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (rx_idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 9);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Compare each accepted result with the oldest predicted status
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_status.size() == 0)
            begin
                $error("unexpected result: %p", out_item);
                errors++;
            end
            else
            begin
                want = pending_status.pop_front();
                if (out_item.lamp !== want.lamp)
                begin
                    $error("lamp: expected %0d, got %0d", want.lamp, out_item.lamp);
                    errors++;
                end
                if (out_item.busy_res !== want.busy_res)
                begin
                    $error("busy_res: expected %0d, got %0d", want.busy_res, out_item.busy_res);
                    errors++;
                end
                if (out_item.blinks_left !== want.blinks_left)
                begin
                    $error("blinks_left: expected %0d, got %0d",
                           want.blinks_left, out_item.blinks_left);
                    errors++;
                end
                if (out_item.burst_total !== want.burst_total)
                begin
                    $error("burst_total: expected %0d, got %0d",
                           want.burst_total, out_item.burst_total);
                    errors++;
                end
            end
        end
    end

    // End the run if nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_commands();
        test_zero_phase();
        test_long_phase();
        test_burst_run();
        test_random();

        wait_idle();
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
design/lbbg_pkg.sv
design/lamp_blink_burst_generator.sv
tb/tb_lamp_blink_burst_generator.sv
